>>> rtl/lpvs_pkg.sv
`timescale 1ns / 1ps

package lpvs_pkg;

	// default sizing
	localparam int NUM_PROCS_DEF      = 16;
	localparam int PAGES_PER_PROC_DEF = 16;
	localparam int PAGE_BYTES_DEF     = 128;

	// fixed field widths
	localparam int PROC_W = 4;
	localparam int PC_W   = 11;
	localparam int RES_W  = 16;
	localparam int ACT_W  = 3;
	localparam int TPG_W  = 4;
	localparam int TS_W   = 32;

	// action codes
	localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_HIT    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PAGEIN = 3'd2;
	localparam logic [ACT_W-1:0] ACT_VICTIM = 3'd3;
	localparam logic [ACT_W-1:0] ACT_NOVIC  = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_SCAN,
		ST_RESOLVE,
		ST_DONE
	} state_t;

	// pages beyond the residency field are never resident
	function automatic logic is_resident(input logic [RES_W-1:0] res,
	                                     input logic [PC_W-1:0] idx);
		logic r;
		r = 1'b0;
		if (idx < PC_W'(RES_W)) begin
			r = res[idx[3:0]];
		end
		return r;
	endfunction

endpackage

>>> rtl/lpvs_ram.sv
`timescale 1ns / 1ps

module lpvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/lru_page_victim_selector.sv
`timescale 1ns / 1ps

// LRU page victim selector.
// Input stream (s_axis_*): one transaction per process slot, slots of a tick in
// process order, s_axis_tlast on the final slot of the tick.
// Output stream (m_axis_*): exactly one result transaction per input transaction,
// action code in m_axis_tuser, m_axis_tlast echoes the input's tlast.
// Sequence: an accepted transaction passes the DIV, CHECK and DONE states;
// a miss with a refused page-in also scans the process's timestamps through
// the single RAM read port, one page per cycle, in SCAN and then RESOLVE.
// One transaction at a time; s_axis_tready is high only while the sequencer
// is idle, so a new transaction is taken only after the last one's result
// has been written to the output register.
// Reset: the timestamp RAM is cleared by a pass over all NUM_PROCS*PAGES_PER_PROC
// entries (256 at default sizing); no input is taken until it completes. The
// tick counter restarts at one.
// Stall: a finished result sits in the output register; the sequencer waits
// for it to drain before writing the next one and returning to idle.

module lru_page_victim_selector
	import lpvs_pkg::*;
#(
	parameter int NUM_PROCS      = NUM_PROCS_DEF,
	parameter int PAGES_PER_PROC = PAGES_PER_PROC_DEF,
	parameter int PAGE_BYTES     = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] proc_index, [4] active, [15:5] program_counter,
	// [31:16] resident_pages, [32] pagein_accepted, [33] pageout_accepted
	input  logic [39:0] s_axis_tdata,
	input  logic        s_axis_tlast,     // last_of_tick
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] target_proc, [7:4] target_page
	output logic [7:0]  m_axis_tdata,
	output logic [2:0]  m_axis_tuser,     // [2:0] action
	output logic        m_axis_tlast      // tick_end
);

	localparam int DEPTH = NUM_PROCS * PAGES_PER_PROC;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PG_W  = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1;
	localparam int CW    = $clog2(PAGES_PER_PROC + 1);

	// page = pc / PAGE_BYTES as a reciprocal multiply, exact for 11-bit pc
	localparam int              DIV_SH = PC_W + $clog2(PAGE_BYTES);
	localparam longint unsigned DIV_M  =
		((64'd1 << DIV_SH) + longint'(PAGE_BYTES) - 1) / longint'(PAGE_BYTES);
	localparam int              DIV_MW = $clog2(DIV_M + 1);
	localparam int              PRD_W  = PC_W + DIV_MW;

	localparam logic [PC_W-1:0] PPP_PC   = PC_W'(PAGES_PER_PROC);
	localparam logic [CW-1:0]   PPP_CW   = CW'(PAGES_PER_PROC);
	localparam logic [CW-1:0]   LAST_IDX = CW'(PAGES_PER_PROC - 1);
	localparam logic [AW-1:0]   LAST_ADR = AW'(DEPTH - 1);

	state_t state_q, state_d;

	// latched input transaction
	logic [PROC_W-1:0] proc_q;
	logic              active_q;
	logic [PC_W-1:0]   pc_q;
	logic [RES_W-1:0]  res_q;
	logic              pin_q;
	logic              pout_q;
	logic              last_q;

	logic [PRD_W-1:0]  prod_q;
	logic [AW-1:0]     base_q;
	logic [PC_W-1:0]   page;

	logic [TS_W-1:0]   tick_q;
	logic              stopped_q;
	logic              stop_set_q;

	logic [AW-1:0]     clr_q;

	// scan unit
	logic [CW-1:0]     rd_idx_q;
	logic [CW-1:0]     cmp_idx_q;
	logic              cmp_vld_q;
	logic [TS_W-1:0]   oldest_q;
	logic [TPG_W-1:0]  vic_q;
	logic              found_q;
	logic              scan_last;

	// result
	logic [ACT_W-1:0]  act_q;
	logic [TPG_W-1:0]  tpage_q;
	logic [PROC_W-1:0] tproc_q;

	logic              out_vld_q;
	logic [7:0]        out_data_q;
	logic [2:0]        out_user_q;
	logic              out_last_q;
	logic              out_free;

	logic              slot_ok;
	logic              page_hit;

	// RAM ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [TS_W-1:0]   ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [TS_W-1:0]   ram_rdata;

	lpvs_ram #(
		.WIDTH (TS_W),
		.DEPTH (DEPTH)
	) u_ts_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign page      = PC_W'(prod_q >> DIV_SH);
	assign slot_ok   = !stopped_q && active_q && (int'(proc_q) < NUM_PROCS) && (page < PPP_PC);
	assign page_hit  = is_resident(res_q, page);
	assign scan_last = cmp_vld_q && (cmp_idx_q == LAST_IDX);
	assign out_free  = !out_vld_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_DIV;
			end
			ST_DIV: state_d = ST_CHECK;
			ST_CHECK: begin
				if (slot_ok && !page_hit && !pin_q) state_d = ST_SCAN;
				else state_d = ST_DONE;
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_RESOLVE;
			end
			ST_RESOLVE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = clr_q;
		ram_wdata     = '0;
		ram_raddr     = base_q + AW'(rd_idx_q[PG_W-1:0]);
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: s_axis_tready = 1'b1;
			ST_CHECK: begin
				// hit: stamp the page with the current tick
				ram_we    = slot_ok && page_hit;
				ram_waddr = base_q + AW'(page[PG_W-1:0]);
				ram_wdata = tick_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			tick_q     <= TS_W'(1);
			stopped_q  <= 1'b0;
			stop_set_q <= 1'b0;
			out_vld_q  <= 1'b0;
			cmp_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);

			if (state_q == ST_CHECK) begin
				stop_set_q <= 1'b0;
				cmp_vld_q  <= 1'b0;
			end
			if (state_q == ST_SCAN) cmp_vld_q <= (rd_idx_q < PPP_CW);
			if (state_q == ST_RESOLVE) stop_set_q <= found_q && pout_q;

			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
				if (last_q) begin
					if (tick_q != '1) tick_q <= tick_q + TS_W'(1);
					stopped_q <= 1'b0;
				end else if (stop_set_q) begin
					stopped_q <= 1'b1;
				end
			end else if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			proc_q   <= s_axis_tdata[3:0];
			active_q <= s_axis_tdata[4];
			pc_q     <= s_axis_tdata[15:5];
			res_q    <= s_axis_tdata[31:16];
			pin_q    <= s_axis_tdata[32];
			pout_q   <= s_axis_tdata[33];
			last_q   <= s_axis_tlast;
		end

		if (state_q == ST_DIV) begin
			prod_q <= PRD_W'(pc_q) * PRD_W'(DIV_M);
			base_q <= AW'(proc_q) * AW'(PAGES_PER_PROC);
		end

		if (state_q == ST_CHECK) begin
			rd_idx_q <= '0;
			oldest_q <= tick_q;
			found_q  <= 1'b0;
			vic_q    <= '0;
			if (slot_ok) tproc_q <= proc_q;
			else tproc_q <= '0;
			if (slot_ok && page_hit) begin
				act_q   <= ACT_HIT;
				tpage_q <= TPG_W'(page);
			end else if (slot_ok && pin_q) begin
				act_q   <= ACT_PAGEIN;
				tpage_q <= TPG_W'(page);
			end else begin
				act_q   <= ACT_NONE;
				tpage_q <= '0;
			end
		end

		if (state_q == ST_SCAN) begin
			if (rd_idx_q < PPP_CW) rd_idx_q <= rd_idx_q + CW'(1);
			cmp_idx_q <= rd_idx_q;
			// strict less-than keeps the lowest index on a tie
			if (cmp_vld_q && is_resident(res_q, PC_W'(cmp_idx_q)) &&
			    (ram_rdata < oldest_q)) begin
				oldest_q <= ram_rdata;
				vic_q    <= TPG_W'(cmp_idx_q);
				found_q  <= 1'b1;
			end
		end

		if (state_q == ST_RESOLVE) begin
			if (found_q) begin
				act_q   <= ACT_VICTIM;
				tpage_q <= vic_q;
			end else begin
				act_q   <= ACT_NOVIC;
				tpage_q <= '0;
			end
		end

		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {tpage_q, tproc_q};
			out_user_q <= act_q;
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lpvs_pkg::*;

	localparam int SLOTS         = NUM_PROCS_DEF;
	localparam int PAGES         = PAGES_PER_PROC_DEF;
	localparam int RANDOM_ITEMS  = 950;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 40;

	// one input transaction, as the block sees it
	typedef struct packed {
		logic [PROC_W-1:0] proc;
		logic              active;
		logic [PC_W-1:0]   pc;
		logic [RES_W-1:0]  res;
		logic              pin_ok;
		logic              pout_ok;
		logic              last;
	} slot_t;

	// one result transaction
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [PROC_W-1:0] proc;
		logic [TPG_W-1:0]  page;
		logic              tick_end;
	} verdict_t;

	// LRU timestamp predictor plus the queue of results it has worked out
	class pager_scoreboard;
		logic [TS_W-1:0] stamp [SLOTS*PAGES];
		logic [TS_W-1:0] tick;
		bit              stopped;
		verdict_t        awaited [$];
		int              errors;

		function new();
			foreach (stamp[i]) stamp[i] = '0;
			tick    = 1;
			stopped = 1'b0;
			errors  = 0;
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		function void note_slot(slot_t s);
			verdict_t        v;
			int              page;
			int              base;
			int              victim;
			logic [TS_W-1:0] oldest;
			bit              found;
			v = '0;
			v.tick_end = s.last;
			if (!stopped && s.active && s.proc < SLOTS) begin
				page = s.pc / PAGE_BYTES_DEF;
				if (page < PAGES) begin
					base   = s.proc * PAGES;
					v.proc = s.proc;
					if (page < RES_W && s.res[page]) begin
						stamp[base + page] = tick;
						v.action = ACT_HIT;
						v.page   = TPG_W'(page);
					end else if (s.pin_ok) begin
						v.action = ACT_PAGEIN;
						v.page   = TPG_W'(page);
					end else begin
						// strictly older than the current tick, first index wins a tie
						oldest = tick;
						found  = 1'b0;
						victim = 0;
						for (int i = 0; i < PAGES; i++) begin
							if (i < RES_W && s.res[i] && stamp[base + i] < oldest) begin
								oldest = stamp[base + i];
								victim = i;
								found  = 1'b1;
							end
						end
						if (found) begin
							v.action = ACT_VICTIM;
							v.page   = TPG_W'(victim);
							if (s.pout_ok) stopped = 1'b1;
						end else begin
							v.action = ACT_NOVIC;
						end
					end
				end
			end
			if (s.last) begin
				if (tick != '1) tick = tick + 1;
				stopped = 1'b0;
			end
			awaited.push_back(v);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(verdict_t got);
			verdict_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing awaited: action %0d proc %0d page %0d",
				       got.action, got.proc, got.page);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("action", 32'(want.action), 32'(got.action));
			compare_field("target_proc", 32'(want.proc), 32'(got.proc));
			compare_field("target_page", 32'(want.page), 32'(got.page));
			compare_field("tick_end", 32'(want.tick_end), 32'(got.tick_end));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	pager_scoreboard sb = new();

	int src_idle_pct = 13;
	int snk_idle_pct = 82;
	int holds_asked  = 0;
	int holds_served = 0;
	int hold_left    = 0;

	// shadow of what each process has resident, evolved to keep victims coming
	logic [RES_W-1:0] resident [SLOTS];

	lru_page_victim_selector uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// receiver: random backpressure, with long hold-offs on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin : take_result
		verdict_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.action   = m_axis_tuser;
			got.proc     = m_axis_tdata[3:0];
			got.page     = m_axis_tdata[7:4];
			got.tick_end = m_axis_tlast;
			sb.check_result(got);
		end
	end

	// entered and left at a falling edge; tvalid is left low
	task automatic go_quiet();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_slot(input slot_t s);
		while ($urandom_range(0, 99) < src_idle_pct) go_quiet();
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, s.pout_ok, s.pin_ok, s.res, s.pc, s.active, s.proc};
		s_axis_tlast  <= s.last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_slot(s);
		@(negedge clk);
	endtask

	task automatic push_slot(input int proc, input bit act, input int pc, input int res,
	                         input bit pin, input bit pout, input bit last);
		slot_t s;
		s.proc    = PROC_W'(proc);
		s.active  = act;
		s.pc      = PC_W'(pc);
		s.res     = RES_W'(res);
		s.pin_ok  = pin;
		s.pout_ok = pout;
		s.last    = last;
		send_slot(s);
	endtask

	// well-formed slot: mostly active, a hit in a little over half the cases
	function automatic slot_t make_slot(int p, bit last);
		slot_t s;
		int    page;
		s.proc    = PROC_W'(p);
		s.last    = last;
		s.active  = ($urandom_range(0, 9) != 0);
		s.pin_ok  = 1'($urandom_range(0, 1));
		s.pout_ok = ($urandom_range(0, 2) == 0);
		if (resident[p] != 0 && $urandom_range(0, 99) < 55) begin
			do page = $urandom_range(0, PAGES - 1); while (!resident[p][page]);
		end else begin
			page = $urandom_range(0, PAGES - 1);
		end
		s.pc  = PC_W'(page * PAGE_BYTES_DEF + $urandom_range(0, PAGE_BYTES_DEF - 1));
		s.res = resident[p];
		if (s.active && !s.res[page] && s.pin_ok) resident[p][page] = 1'b1;
		if ($urandom_range(0, 5) == 0) resident[p][$urandom_range(0, PAGES - 1)] = 1'b0;
		if ($urandom_range(0, 80) == 0) resident[p] = $urandom_range(0, 1) ? '1 : '0;
		return s;
	endfunction

	initial begin
		slot_t            s;
		logic [SLOTS-1:0] pick;
		int               sent;
		int               phase;
		int               top;
		foreach (resident[i]) resident[i] = RES_W'($urandom);
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// tick 1: inactive, hits at both page extremes, page-in, empty scan,
		// refused then accepted page-out, skipped slots after the stop
		push_slot(0, 0, 0, 16'h0000, 0, 0, 0);
		push_slot(0, 1, 0, 16'h0001, 0, 0, 0);
		push_slot(1, 1, 2047, 16'hFFFF, 0, 0, 0);
		push_slot(2, 1, 384, 16'h0000, 1, 0, 0);
		push_slot(3, 1, 0, 16'h0000, 0, 1, 0);
		push_slot(4, 1, 0, 16'h0006, 0, 0, 0);
		push_slot(5, 1, 0, 16'h0006, 0, 1, 0);
		push_slot(6, 1, 0, 16'h0001, 0, 0, 0);
		push_slot(15, 1, 0, 16'h0001, 0, 0, 1);
		// tick 2: stale stamps become victims; a page touched this tick is not one
		push_slot(0, 1, 128, 16'h0001, 0, 0, 0);
		push_slot(1, 1, 0, 16'h8000, 0, 0, 0);
		push_slot(7, 1, 0, 16'h0003, 0, 0, 0);
		push_slot(7, 1, 128, 16'h0001, 0, 1, 0);
		push_slot(15, 1, 2047, 16'h7FFF, 0, 1, 0);
		push_slot(15, 1, 2047, 16'hFFFF, 1, 1, 1);
		// tick 3: all-ones fields after the stop has been cleared
		push_slot(14, 0, 2047, 16'hFFFF, 1, 1, 0);
		push_slot(15, 1, 2047, 16'hFFFF, 1, 1, 1);

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase == 0 && sent >= RANDOM_ITEMS / 3) begin
				// sender pause: let every awaited result drain first
				phase = 1;
				go_quiet();
				while (sb.outstanding() != 0) @(negedge clk);
				src_idle_pct = 82;
				snk_idle_pct = 13;
			end
			if (phase == 1 && sent >= 2 * RANDOM_ITEMS / 3) begin
				phase = 2;
				src_idle_pct = 0;
				snk_idle_pct = 0;
				holds_asked++;
			end
			if ($urandom_range(0, 9) == 0) begin
				// noise: any process, any content, tlast anywhere
				s.proc    = PROC_W'($urandom);
				s.active  = 1'($urandom);
				s.pc      = PC_W'($urandom);
				s.res     = RES_W'($urandom);
				s.pin_ok  = 1'($urandom);
				s.pout_ok = 1'($urandom);
				s.last    = 1'($urandom);
				send_slot(s);
				sent++;
			end else begin
				pick = ($urandom_range(0, 2) == 0) ? '1 : SLOTS'($urandom);
				if (pick == 0) pick[$urandom_range(0, SLOTS - 1)] = 1'b1;
				top = 0;
				for (int p = 0; p < SLOTS; p++) if (pick[p]) top = p;
				for (int p = 0; p < SLOTS; p++) begin
					if (pick[p]) begin
						send_slot(make_slot(p, p == top));
						sent++;
					end
				end
			end
		end

		go_quiet();
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
